/* rtl/core/rgmm_pkg.sv */
// Package for the ramped gain matrix mixer: sizes, opcodes, register map,
// sequencer states. No dependencies.
`default_nettype none
package rgmm_pkg;
	localparam int MaxChannels = 32;
	localparam int MaxGains    = 1024;
	localparam int ChW   = $clog2(MaxChannels);
	localparam int GW    = $clog2(MaxGains);
	localparam int CntW  = ChW + 1;
	localparam int ElemW = 2 * CntW;
	localparam logic [23:0] GainOne = 24'h100000;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_WRITE  = 2'd1,
		OP_SNAP   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_ROWS   = 2'd0,
		REG_COLS   = 2'd1,
		REG_RAMP   = 2'd2,
		REG_FREEZE = 2'd3
	} reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_UPD,
		ST_MIX,
		ST_EMIT
	} state_t;

	// Clamp a count register to 1..MaxChannels.
	function automatic logic [CntW-1:0] clamp_count(input logic [5:0] v);
		logic [CntW-1:0] r;
		if (v == 6'd0) r = CntW'(1);
		else if (32'(v) > MaxChannels) r = CntW'(MaxChannels);
		else r = CntW'(v);
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/core/ramped_gain_matrix_mixer.sv */
// Ramped gain matrix mixer top level: register file, gain memories,
// sequencer and multiply-accumulate datapath. Depends on rgmm_pkg.
//
// Timing: a target write, an unused opcode, or a sample that does not end a
// frame leaves the sequencer idle. A snap command, and a frame end with
// freeze clear, sweep rows*cols gain entries through the memory at one entry
// per cycle, through the read and write-back registers. A frame end then mixes
// (with freeze set it goes straight to the mix), walking each row at one
// multiply-accumulate per column and strobing each output for a single cycle;
// results cannot be held off. After reset a clearing pass writes GainOne at
// entries 0 and 3 and zero elsewhere (the 2x2 identity) into both gain memories,
// with busy high. busy is high for the whole of any sweep.
`default_nettype none
module ramped_gain_matrix_mixer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [9:0]  gain_index,
	input  wire logic signed [23:0] value,
	output logic             strobe,
	output logic signed [23:0] out_sample,
	output logic [4:0]       out_channel,
	output logic             last
);
	import rgmm_pkg::*;

	// registers
	logic [5:0]  rows_q, cols_q;
	logic [15:0] ramp_q;
	logic        freeze_q;
	logic        wr_en;
	reg_t        reg_sel;
	assign pready  = 1'b1;
	assign reg_sel = reg_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 6'd2; cols_q <= 6'd2; ramp_q <= '0; freeze_q <= 1'b0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_ROWS:   rows_q   <= pwdata[5:0];
				REG_COLS:   cols_q   <= pwdata[5:0];
				REG_RAMP:   ramp_q   <= pwdata[15:0];
				REG_FREEZE: freeze_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_ROWS:   prdata = {26'd0, rows_q};
			REG_COLS:   prdata = {26'd0, cols_q};
			REG_RAMP:   prdata = {16'd0, ramp_q};
			REG_FREEZE: prdata = {31'd0, freeze_q};
			default:    prdata = '0;
		endcase
	end

	logic [CntW-1:0] rows, cols;
	logic [ElemW-1:0] elem;
	assign rows = clamp_count(rows_q);
	assign cols = clamp_count(cols_q);
	assign elem = ElemW'(rows) * ElemW'(cols);

	// memories
	logic [23:0] tgt_mem [MaxGains];
	logic [23:0] act_mem [MaxGains];
	logic [23:0] smp_mem [MaxChannels];
	logic          t_we, a_we;
	logic [GW-1:0] t_wa, a_wa, t_ra, a_ra;
	logic [23:0]   t_wd, a_wd, t_rd, a_rd, s_rd, s_wd;
	logic          s_we;
	logic [ChW-1:0] s_wa, s_ra;

	always_ff @(posedge clk) begin
		if (t_we) tgt_mem[t_wa] <= t_wd;
		if (a_we) act_mem[a_wa] <= a_wd;
		if (s_we) smp_mem[s_wa] <= s_wd;
		t_rd <= tgt_mem[t_ra];
		a_rd <= act_mem[a_ra];
		s_rd <= smp_mem[s_ra];
	end

	// sequencer
	state_t state_q, state_d;
	logic [GW:0]      clr_q;
	logic [ElemW-1:0] k_q;       // sweep read index
	logic             rd_v_s1, rd_v_s2;
	logic [GW-1:0]    rd_a_s1, rd_a_s2;
	logic             ramp_mode_q;
	logic [ChW:0]     ccount_q;
	logic [CntW-1:0]  r_q, c_q;
	logic [GW:0]      rbase_q;
	logic signed [55:0] acc_q;
	logic             mac_v_s1, mac_v_s2, mac_ok_s1, mac_ok_s2;
	logic signed [47:0] prod_s2;

	logic take, frame_end, sweep_rd, mix_rd, mix_done, upd_done;
	assign take = start && !busy;
	assign frame_end = take && op_t'(op) == OP_SAMPLE &&
		(32'(ccount_q) + 1 >= 32'(cols) || 32'(ccount_q) >= MaxChannels);
	assign sweep_rd = (state_q == ST_UPD) && (k_q < elem) && (32'(k_q) < MaxGains);
	assign upd_done = (state_q == ST_UPD) && !sweep_rd && !rd_v_s1 && !rd_v_s2;
	assign mix_rd   = (state_q == ST_MIX) && (c_q < cols);
	assign mix_done = (state_q == ST_MIX) && !mix_rd && !mac_v_s1 && !mac_v_s2;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == (GW+1)'(MaxGains - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (take && op_t'(op) == OP_SNAP) state_d = ST_UPD;
				else if (frame_end) state_d = freeze_q ? ST_MIX : ST_UPD;
			end
			ST_UPD:  if (upd_done) state_d = ramp_mode_q ? ST_MIX : ST_IDLE;
			ST_MIX:  if (mix_done) state_d = ST_EMIT;
			ST_EMIT: state_d = (r_q + 1'b1 == rows) ? ST_IDLE : ST_MIX;
			default: state_d = ST_IDLE;
		endcase
	end
	// ramp_mode_q here also flags "frame pending mix" after update

	always_comb begin
		busy = (state_q != ST_IDLE);
		strobe = (state_q == ST_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; clr_q <= '0; k_q <= '0; ccount_q <= '0;
			rd_v_s1 <= 1'b0; rd_v_s2 <= 1'b0; mac_v_s1 <= 1'b0; mac_v_s2 <= 1'b0;
			ramp_mode_q <= 1'b0; r_q <= '0; c_q <= '0; rbase_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			rd_v_s1 <= sweep_rd;
			rd_v_s2 <= rd_v_s1;
			mac_v_s1 <= mix_rd;
			mac_v_s2 <= mac_v_s1;
			if (sweep_rd) k_q <= k_q + 1'b1;
			if (mix_rd) c_q <= c_q + 1'b1;
			if (take && op_t'(op) == OP_SAMPLE)
				ccount_q <= frame_end ? '0 : ccount_q + 1'b1;
			if (state_q == ST_IDLE) begin
				k_q <= '0; c_q <= '0; r_q <= '0; rbase_q <= '0;
				ramp_mode_q <= frame_end;
			end
			if (state_q == ST_EMIT) begin
				r_q <= r_q + 1'b1;
				rbase_q <= rbase_q + (GW+1)'(cols);
				c_q <= '0;
			end
		end
	end

	// ramp: c*active + (65536-c)*target, rounded half up, registered with the copy path
	logic signed [41:0] ramp_pa, ramp_pt, ramp_sum, ramp_p_s2;
	logic signed [23:0] ramp_val;
	logic signed [17:0] cf, cr;
	logic [23:0]        tgt_s2;
	assign cf = {2'b00, ramp_q};
	assign cr = 18'sd65536 - cf;
	always_comb begin
		ramp_pa  = 42'(cf) * 42'($signed(a_rd));
		ramp_pt  = 42'(cr) * 42'($signed(t_rd));
		ramp_sum = ramp_pa + ramp_pt + 42'sd32768;
	end
	always_ff @(posedge clk) begin
		ramp_p_s2 <= ramp_sum;
		tgt_s2    <= t_rd;
	end
	assign ramp_val = ramp_p_s2[39:16];
	always_ff @(posedge clk) rd_a_s1 <= GW'(k_q);
	always_ff @(posedge clk) rd_a_s2 <= rd_a_s1;

	// memory ports
	logic upd_ramp;
	assign upd_ramp = ramp_mode_q && (ramp_q != 16'd0);
	always_comb begin
		t_we = 1'b0; t_wa = gain_index; t_wd = value;
		a_we = 1'b0; a_wa = rd_a_s2; a_wd = tgt_s2;
		t_ra = GW'(k_q); a_ra = GW'(k_q);
		s_we = take && op_t'(op) == OP_SAMPLE;
		s_wa = (32'(ccount_q) >= MaxChannels) ? '0 : ChW'(ccount_q);
		s_wd = value;
		s_ra = ChW'(c_q);
		if (state_q == ST_CLEAR) begin
			t_we = 1'b1; a_we = 1'b1; t_wa = GW'(clr_q); a_wa = GW'(clr_q);
			t_wd = (clr_q == '0 || clr_q == (GW+1)'(3)) ? GainOne : '0;
			a_wd = t_wd;
		end else if (take && op_t'(op) == OP_WRITE) begin
			t_we = 1'b1;
		end
		if (rd_v_s2) begin
			a_we = 1'b1;
			a_wd = upd_ramp ? ramp_val : tgt_s2;
		end
		if (state_q == ST_MIX) a_ra = GW'(rbase_q + (GW+1)'(c_q));
	end
	logic mix_ok_rd;
	assign mix_ok_rd = 32'(rbase_q) + 32'(c_q) < MaxGains;

	// mix MAC: read, multiply, accumulate
	always_ff @(posedge clk) begin
		mac_ok_s1 <= mix_ok_rd;
		mac_ok_s2 <= mac_ok_s1;
		prod_s2 <= mac_ok_s1 ? $signed(a_rd) * $signed(s_rd) : 48'sd0;
		if (state_q == ST_EMIT || state_q == ST_IDLE) acc_q <= '0;
		else if (mac_v_s2 && mac_ok_s2) acc_q <= acc_q + 56'(prod_s2);
	end

	// round, shift and saturate
	logic signed [56:0] rnd;
	always_comb begin
		rnd = 57'(acc_q) + 57'sd524288;
		if ($signed(rnd[56:20]) > 37'sd8388607) out_sample = 24'sh7FFFFF;
		else if ($signed(rnd[56:20]) < -37'sd8388608) out_sample = -24'sh800000;
		else out_sample = rnd[43:20];
		out_channel = r_q[4:0];
		last = (r_q + 1'b1 == rows);
	end
endmodule
`default_nettype wire

/* rtl/core/rgmm_checker.sv */
// Port-level checker for the mixer, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module rgmm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic busy,
	input wire logic strobe,
	input wire logic last,
	input wire logic pready
);
	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n) strobe |-> busy)
		else $error("beat while idle");
	a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> !strobe) else $error("beats back to back");
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe) else $error("beat after last");
endmodule
bind ramped_gain_matrix_mixer rgmm_checker u_chk (.*);
`default_nettype wire

/* test/tb_ramped_gain_matrix_mixer.sv */
// Self-checking testbench for ramped_gain_matrix_mixer: directed and random commands
// checked against an in-bench mixer predictor. Depends on rgmm_pkg and the mixer RTL.
`timescale 1ns / 1ps
module tb_ramped_gain_matrix_mixer;
	import rgmm_pkg::*;

	localparam longint CycleLimit = 3000000;

	typedef struct {
		logic signed [23:0] smp;
		logic [4:0]         chan;
		logic               lst;
	} mix_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = OP_NONE;
	logic [9:0]  gain_index = '0;
	logic signed [23:0] value = '0;
	logic        strobe;
	logic signed [23:0] out_sample;
	logic [4:0]  out_channel;
	logic        last;

	ramped_gain_matrix_mixer u_dut (.*);

	// mirror of the block's state
	logic [5:0]         rows_cfg, cols_cfg;
	logic [15:0]        ramp_cfg;
	logic               freeze_cfg;
	logic signed [23:0] target_gain [MaxGains];
	logic signed [23:0] active_gain [MaxGains];
	logic signed [23:0] frame_smp [MaxChannels];
	int                 chan_count;

	mix_out_t   pending_mix[$];
	int         error_count = 0;
	int         items_sent = 0;
	int         mixes_seen = 0;
	int         frames_done = 0;
	int         burst_left = 0;
	longint     cycles = 0;

	initial forever #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int eff_count(logic [5:0] v);
		if (v == 0) return 1;
		if (v > MaxChannels) return MaxChannels;
		return v;
	endfunction

	// ramp or snap the first rows*cols gains
	function automatic void update_gains(bit snap_only);
		int     elem;
		longint s;
		elem = eff_count(rows_cfg) * eff_count(cols_cfg);
		for (int k = 0; k < elem && k < MaxGains; k++) begin
			if (snap_only || ramp_cfg == 0) begin
				active_gain[k] = target_gain[k];
			end else begin
				s = longint'(ramp_cfg) * active_gain[k]
					+ longint'(65536 - ramp_cfg) * target_gain[k] + 32768;
				active_gain[k] = 24'(s >>> 16);
			end
		end
	endfunction

	// predict the outputs caused by one accepted command
	function automatic void mixer_predict(op_t o, logic [9:0] gi, logic signed [23:0] v);
		int       rows, cols;
		longint   acc;
		mix_out_t m;
		rows = eff_count(rows_cfg);
		cols = eff_count(cols_cfg);
		case (o)
			OP_WRITE: target_gain[gi] = v;
			OP_SNAP: update_gains(1'b1);
			OP_SAMPLE: begin
				if (chan_count >= MaxChannels) chan_count = 0;
				frame_smp[chan_count] = v;
				if (chan_count + 1 < cols) begin
					chan_count++;
				end else begin
					chan_count = 0;
					frames_done++;
					if (!freeze_cfg) update_gains(1'b0);
					for (int r = 0; r < rows; r++) begin
						acc = 0;
						for (int c = 0; c < cols; c++)
							acc += longint'(active_gain[r * cols + c]) * frame_smp[c];
						acc = (acc + (longint'(1) << 19)) >>> 20;
						if (acc > 8388607) acc = 8388607;
						if (acc < -8388608) acc = -8388608;
						m.smp = 24'(acc);
						m.chan = 5'(r);
						m.lst = (r + 1 == rows);
						pending_mix.push_back(m);
					end
				end
			end
			default: ;
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		mix_out_t e;
		if (arst_n && strobe) begin
			mixes_seen++;
			if (pending_mix.size() == 0) begin
				$error("unexpected output beat: out_sample %0d", out_sample);
				error_count++;
			end else begin
				e = pending_mix.pop_front();
				if (out_sample !== e.smp) begin
					$error("out_sample exp %0d got %0d", e.smp, out_sample);
					error_count++;
				end
				if (out_channel !== e.chan) begin
					$error("out_channel exp %0d got %0d", e.chan, out_channel);
					error_count++;
				end
				if (last !== e.lst) begin
					$error("last exp %0d got %0d", e.lst, last);
					error_count++;
				end
			end
		end
	end

	// send one command beat; sender idles in random bursts
	task automatic send_cmd(op_t o, logic [9:0] gi, logic signed [23:0] v);
		@(negedge clk);
		start = 1'b1;
		op = o;
		gain_index = gi;
		value = v;
		do @(posedge clk); while (busy);
		mixer_predict(o, gi, v);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
		end
	endtask

	// stop sending and let every expected beat and any sweep finish
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending_mix.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic reg_write(reg_t idx, logic [31:0] d);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = 4'(idx * 4);
		pwdata = d;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_ROWS:   rows_cfg = d[5:0];
			REG_COLS:   cols_cfg = d[5:0];
			REG_RAMP:   ramp_cfg = d[15:0];
			REG_FREEZE: freeze_cfg = d[0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_shape(int rows, int cols, int ramp, bit frz);
		drain();
		reg_write(REG_ROWS, rows);
		reg_write(REG_COLS, cols);
		reg_write(REG_RAMP, ramp);
		reg_write(REG_FREEZE, frz);
	endtask

	task automatic send_frame();
		int cols;
		cols = eff_count(cols_cfg);
		for (int c = chan_count; c < cols; c++) send_cmd(OP_SAMPLE, '0, 24'($urandom));
	endtask

	// identity gains at reset, extreme samples
	task automatic test_reset_identity();
		send_cmd(OP_SAMPLE, '0, 24'sh7FFFFF);
		send_cmd(OP_SAMPLE, '0, -24'sd8388608);
		send_cmd(OP_SAMPLE, 10'h3FF, 24'sd0);
		send_cmd(OP_SAMPLE, 10'h2AA, -24'sd1);
	endtask

	// target writes, snap, saturation both ways
	task automatic test_target_snap();
		send_cmd(OP_WRITE, 10'd0, 24'sh7FFFFF);
		send_cmd(OP_WRITE, 10'd1, 24'sh7FFFFF);
		send_cmd(OP_WRITE, 10'd2, -24'sd8388608);
		send_cmd(OP_WRITE, 10'd3, -24'sd8388608);
		send_cmd(OP_WRITE, 10'h3FF, 24'sh155555);
		send_cmd(OP_SNAP, '0, '0);
		send_cmd(OP_SAMPLE, '0, 24'sh7FFFFF);
		send_cmd(OP_SAMPLE, '0, 24'sh7FFFFF);
		send_cmd(OP_SAMPLE, '0, -24'sd8388608);
		send_cmd(OP_SAMPLE, '0, -24'sd8388608);
	endtask

	// ramping toward target, then frozen, then full-scale and minimal coefficients
	task automatic test_ramp_freeze();
		set_shape(2, 2, 16'h8000, 1'b0);
		send_cmd(OP_WRITE, 10'd0, 24'sh100000);
		send_cmd(OP_WRITE, 10'd3, -24'sh080000);
		repeat (2) send_frame();
		set_shape(2, 2, 16'h8000, 1'b1);
		send_frame();
		set_shape(2, 2, 16'hFFFF, 1'b0);
		send_frame();
		set_shape(2, 2, 16'h0001, 1'b0);
		send_frame();
	endtask

	// counts of zero and above the maximum, largest matrix, shrinking mid-frame
	task automatic test_counts();
		set_shape(0, 0, 0, 1'b0);
		send_frame();
		set_shape(63, 63, 16'h4000, 1'b0);
		send_frame();
		set_shape(2, 4, 0, 1'b0);
		send_cmd(OP_SAMPLE, '0, 24'sh123456);
		send_cmd(OP_SAMPLE, '0, -24'sh234567);
		send_cmd(OP_SAMPLE, '0, 24'sh345678);
		drain();
		reg_write(REG_COLS, 2);
		send_cmd(OP_SAMPLE, '0, 24'sh400000);
	endtask

	// unused opcode does nothing
	task automatic test_unused_op();
		send_cmd(OP_NONE, 10'h3FF, 24'sh7FFFFF);
		send_cmd(OP_NONE, '0, '0);
		send_frame();
	endtask

	// random phases: mostly frame samples with gain writes, snaps and unused opcodes mixed in
	task automatic test_random(int n_items);
		int rows, cols, pick, stop_at;
		while (items_sent < n_items) begin
			if (chan_count != 0) send_frame();
			rows = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 6);
			cols = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 6);
			pick = $urandom_range(0, 3);
			set_shape(rows, cols,
				(pick == 0) ? 0 : (pick == 1) ? 16'hFFFF : $urandom_range(0, 65535),
				($urandom_range(0, 4) == 0));
			stop_at = items_sent + $urandom_range(10, 40);
			while (items_sent < stop_at) begin
				pick = $urandom_range(0, 19);
				if (pick < 12) begin
					send_cmd(OP_SAMPLE, 10'($urandom), 24'($urandom));
				end else if (pick < 17) begin
					send_cmd(OP_WRITE,
						($urandom_range(0, 3) == 0) ? 10'($urandom)
							: 10'($urandom_range(0, eff_count(rows_cfg) * eff_count(cols_cfg) - 1)),
						($urandom_range(0, 1) == 0) ? 24'($urandom)
							: 24'($urandom_range(0, 24'h200000) - 24'h100000));
				end else if (pick < 19) begin
					send_cmd(OP_SNAP, 10'($urandom), 24'($urandom));
				end else begin
					send_cmd(OP_NONE, 10'($urandom), 24'($urandom));
				end
			end
		end
		send_frame();
	endtask

	initial begin
		rows_cfg = 6'd2;
		cols_cfg = 6'd2;
		ramp_cfg = '0;
		freeze_cfg = 1'b0;
		chan_count = 0;
		for (int k = 0; k < MaxGains; k++) begin
			target_gain[k] = '0;
			active_gain[k] = '0;
		end
		target_gain[0] = GainOne;
		target_gain[3] = GainOne;
		active_gain[0] = GainOne;
		active_gain[3] = GainOne;
		for (int c = 0; c < MaxChannels; c++) frame_smp[c] = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_identity();
		test_target_snap();
		test_ramp_freeze();
		test_counts();
		test_unused_op();
		test_random(300);
		drain();
		repeat (50) @(posedge clk);

		$display("Covered %0d commands, %0d frames, %0d mixed output beats;",
			items_sent, frames_done, mixes_seen);
		$display("snap, ramp, freeze, clamped counts and mid-frame column shrink included.");
		if (error_count == 0 && pending_mix.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

/* sim.f */
rtl/core/rgmm_pkg.sv
rtl/core/ramped_gain_matrix_mixer.sv
rtl/core/rgmm_checker.sv
test/tb_ramped_gain_matrix_mixer.sv
